FILE: rtl/core/dbhu_pkg.sv
// ----------------------------------------------------------------------------
// dbhu_pkg
// Shared types and constants of the detector bank hit unpacker: parse
// phases, fault codes, register indexes and the result record layout.
// ----------------------------------------------------------------------------
package dbhu_pkg;

    // number of hit groups that follow the preamble
    localparam int GROUPS_PER_BANK_DEFAULT = 4;

    // register reset values
    localparam logic [15:0] MAGIC_VALUE_RESET  = 16'd52171;
    localparam logic [7:0]  SOURCE_LIMIT_RESET = 8'd14;

    // register indexes on the configuration port
    localparam logic CFG_MAGIC_VALUE  = 1'b0;
    localparam logic CFG_SOURCE_LIMIT = 1'b1;

    // header checks
    localparam logic [15:0] MIN_BANK_BYTES = 16'd12;

    // station group boundaries on the source number
    localparam logic [7:0] STATION_BOUND_0 = 8'd4;
    localparam logic [7:0] STATION_BOUND_1 = 8'd6;
    localparam logic [7:0] STATION_BOUND_2 = 8'd8;

    // result kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // fault codes
    localparam logic [2:0] FAULT_NONE       = 3'd0;
    localparam logic [2:0] FAULT_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] FAULT_TOO_SHORT  = 3'd2;
    localparam logic [2:0] FAULT_PREAMBLE   = 3'd3;
    localparam logic [2:0] FAULT_BAD_SOURCE = 3'd4;
    localparam logic [2:0] FAULT_LENGTH     = 3'd5;

    // result queue, in entries of one or two records
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_COUNT,
        PH_HITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [15:0] magic_value;
        logic [7:0]  source_limit;
    } cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [11:0] channel_address;
        logic [3:0]  time_value;
        logic [1:0]  station_group;
        logic [1:0]  group_index;
        logic [2:0]  fault_code;
        logic        last_of_run;
    } rec_t;

    // all records caused by one accepted word
    typedef struct packed {
        logic two;
        rec_t r0;
        rec_t r1;
    } pair_t;

endpackage

FILE: rtl/core/dbhu_parser.sv
// ----------------------------------------------------------------------------
// dbhu_parser
// Bank parse state and per-word decode: header checks, preamble skip,
// group counts and hit words, giving up to two records per word.
// ----------------------------------------------------------------------------
module dbhu_parser #(
    parameter int GROUPS_PER_BANK = dbhu_pkg::GROUPS_PER_BANK_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dbhu_pkg::cfg_t    cfg,
    input  logic              word_valid,
    input  logic [15:0]       bank_word,
    input  logic              first_word,
    input  logic              last_word,
    input  logic [7:0]        source_number,
    input  logic [15:0]       header_magic,
    input  logic [15:0]       bank_bytes,
    output logic              push_valid,
    output dbhu_pkg::pair_t   push_data
);

    localparam logic [3:0] GROUP_COUNT = 4'(GROUPS_PER_BANK);

    dbhu_pkg::phase_t phase_reg, phase_next, phase_mid;
    logic [16:0] words_left_reg, words_left_next, words_left_mid;
    logic [2:0]  group_reg, group_next, group_mid;
    logic [1:0]  station_reg, station_next, station_mid;
    logic        faulted_reg, faulted_next, faulted_mid;

    logic        word_rec_valid;
    logic        word_rec_kind;
    logic [2:0]  word_rec_code;
    logic        end_rec_valid;

    logic [16:0] pre_sum;
    logic [16:0] pre_len;
    logic [1:0]  station_calc;
    logic [2:0]  header_code;
    logic        group_final;

    // preamble length 2*((w+3)/2) words, first word included
    assign pre_sum = {1'b0, bank_word} + 17'd3;
    assign pre_len = {pre_sum[16:1], 1'b0};

    // station group from the source number
    always_comb
    begin
        priority if (source_number < dbhu_pkg::STATION_BOUND_0)
            station_calc = 2'd0;
        else if (source_number < dbhu_pkg::STATION_BOUND_1)
            station_calc = 2'd1;
        else if (source_number < dbhu_pkg::STATION_BOUND_2)
            station_calc = 2'd2;
        else
            station_calc = 2'd3;
    end

    // header checks, first failing one wins
    always_comb
    begin
        priority if (header_magic != cfg.magic_value)
            header_code = dbhu_pkg::FAULT_BAD_MAGIC;
        else if (source_number >= cfg.source_limit)
            header_code = dbhu_pkg::FAULT_BAD_SOURCE;
        else if (bank_bytes < dbhu_pkg::MIN_BANK_BYTES)
            header_code = dbhu_pkg::FAULT_TOO_SHORT;
        else if ({2'b00, bank_bytes[15:1]} < pre_len)
            header_code = dbhu_pkg::FAULT_PREAMBLE;
        else
            header_code = dbhu_pkg::FAULT_NONE;
    end

    assign group_final = ({1'b0, group_reg} + 4'd1) >= GROUP_COUNT;

    // effect of the word itself, before end-of-bank handling
    always_comb
    begin
        phase_mid      = phase_reg;
        words_left_mid = words_left_reg;
        group_mid      = group_reg;
        station_mid    = station_reg;
        faulted_mid    = faulted_reg;
        word_rec_valid = 1'b0;
        word_rec_kind  = dbhu_pkg::KIND_HIT;
        word_rec_code  = dbhu_pkg::FAULT_NONE;
        if (first_word)
        begin
            station_mid = station_calc;
            group_mid   = 3'd0;
            faulted_mid = 1'b0;
            if (header_code != dbhu_pkg::FAULT_NONE)
            begin
                word_rec_valid = 1'b1;
                word_rec_kind  = dbhu_pkg::KIND_ERROR;
                word_rec_code  = header_code;
                faulted_mid    = 1'b1;
                words_left_mid = 17'd0;
                phase_mid      = dbhu_pkg::PH_PREAMBLE;
            end
            else
            begin
                // preamble is at least two words, so one at least remains
                words_left_mid = pre_len - 17'd1;
                phase_mid      = dbhu_pkg::PH_PREAMBLE;
            end
        end
        else if (phase_reg != dbhu_pkg::PH_IDLE && !faulted_reg)
        begin
            unique case (phase_reg)
                dbhu_pkg::PH_PREAMBLE:
                begin
                    words_left_mid = words_left_reg - 17'd1;
                    if (words_left_mid == 17'd0)
                        phase_mid = dbhu_pkg::PH_COUNT;
                end
                dbhu_pkg::PH_COUNT:
                begin
                    words_left_mid = {1'b0, bank_word};
                    if (bank_word == 16'd0)
                    begin
                        if (group_final)
                            phase_mid = dbhu_pkg::PH_DONE;
                        else
                        begin
                            group_mid = group_reg + 3'd1;
                            phase_mid = dbhu_pkg::PH_COUNT;
                        end
                    end
                    else
                        phase_mid = dbhu_pkg::PH_HITS;
                end
                dbhu_pkg::PH_HITS:
                begin
                    word_rec_valid = 1'b1;
                    words_left_mid = words_left_reg - 17'd1;
                    if (words_left_mid == 17'd0)
                    begin
                        if (group_final)
                            phase_mid = dbhu_pkg::PH_DONE;
                        else
                        begin
                            group_mid = group_reg + 3'd1;
                            phase_mid = dbhu_pkg::PH_COUNT;
                        end
                    end
                end
                default:
                begin
                    // word after the last group: overrun
                    word_rec_valid = 1'b1;
                    word_rec_kind  = dbhu_pkg::KIND_ERROR;
                    word_rec_code  = dbhu_pkg::FAULT_LENGTH;
                    faulted_mid    = 1'b1;
                end
            endcase
        end
    end

    // next state: end of bank returns to idle
    always_comb
    begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        group_next      = group_reg;
        station_next    = station_reg;
        faulted_next    = faulted_reg;
        if (word_valid)
        begin
            phase_next      = phase_mid;
            words_left_next = words_left_mid;
            group_next      = group_mid;
            station_next    = station_mid;
            faulted_next    = faulted_mid;
            if (last_word)
            begin
                phase_next      = dbhu_pkg::PH_IDLE;
                words_left_next = 17'd0;
                group_next      = 3'd0;
                faulted_next    = 1'b0;
            end
        end
    end

    // records for this word
    always_comb
    begin
        dbhu_pkg::rec_t word_rec;
        dbhu_pkg::rec_t end_rec;

        // a stray word outside any bank causes nothing, final or not
        end_rec_valid = last_word && !faulted_mid && phase_mid != dbhu_pkg::PH_DONE &&
                        (first_word || phase_reg != dbhu_pkg::PH_IDLE);

        word_rec.result_kind     = word_rec_kind;
        word_rec.channel_address = (word_rec_kind == dbhu_pkg::KIND_HIT) ?
                                   bank_word[11:0] : 12'd0;
        word_rec.time_value      = (word_rec_kind == dbhu_pkg::KIND_HIT) ?
                                   bank_word[15:12] : 4'd0;
        word_rec.station_group   = station_mid;
        word_rec.group_index     = first_word ? 2'd0 : group_reg[1:0];
        word_rec.fault_code      = word_rec_code;
        word_rec.last_of_run     = !end_rec_valid;

        end_rec.result_kind      = dbhu_pkg::KIND_ERROR;
        end_rec.channel_address  = 12'd0;
        end_rec.time_value       = 4'd0;
        end_rec.station_group    = station_mid;
        end_rec.group_index      = group_mid[1:0];
        end_rec.fault_code       = dbhu_pkg::FAULT_LENGTH;
        end_rec.last_of_run      = 1'b1;

        push_valid    = word_valid && (word_rec_valid || end_rec_valid);
        push_data.two = word_rec_valid && end_rec_valid;
        push_data.r0  = word_rec_valid ? word_rec : end_rec;
        push_data.r1  = end_rec;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dbhu_pkg::PH_IDLE;
            words_left_reg <= 17'd0;
            group_reg      <= 3'd0;
            station_reg    <= 2'd0;
            faulted_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            group_reg      <= group_next;
            station_reg    <= station_next;
            faulted_reg    <= faulted_next;
        end
    end

endmodule

FILE: rtl/core/dbhu_out_queue.sv
// ----------------------------------------------------------------------------
// dbhu_out_queue
// Small queue of record pairs between the parser and the output stream;
// each entry holds the one or two records of one word and is sent a
// record at a time.
// ----------------------------------------------------------------------------
module dbhu_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  dbhu_pkg::pair_t   push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output dbhu_pkg::rec_t    out_rec
);

    localparam int PTR_W = $clog2(dbhu_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dbhu_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(dbhu_pkg::QUEUE_DEPTH);

    dbhu_pkg::pair_t  entry_reg [dbhu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sub_reg, sub_next;
    logic             push;
    logic             pop;
    logic             send;

    // head record, second half once the first has gone
    assign out_valid  = count_reg != '0;
    assign out_rec    = sub_reg ? entry_reg[rd_ptr_reg].r1 : entry_reg[rd_ptr_reg].r0;
    assign push_ready = count_reg != DEPTH_CNT;

    assign push = push_valid && push_ready;
    assign send = out_valid && out_ready;
    assign pop  = send && (sub_reg || !entry_reg[rd_ptr_reg].two);

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        sub_next    = sub_reg;
        if (pop)
            sub_next = 1'b0;
        else if (send)
            sub_next = 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/detector_bank_hit_unpacker.sv
// ----------------------------------------------------------------------------
// detector_bank_hit_unpacker
// Top level: configuration registers, bank parser and result queue.
// ----------------------------------------------------------------------------
// Takes one bank word per cycle and decodes it in the cycle it is accepted;
// each word yields zero, one or two records (a hit, a header or length
// fault, or a hit followed by a length fault on the final word). Records of
// up to two words wait in the result queue and leave one per cycle, so the
// input keeps a word per cycle as long as the output takes a record per
// cycle on average; s_tready falls only when two words' records are still
// unsent. The result of an accepted word can appear on the output in the
// following cycle.
module detector_bank_hit_unpacker #(
    parameter int GROUPS_PER_BANK = dbhu_pkg::GROUPS_PER_BANK_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // bank words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // bank_word, source_number, header_magic, bank_bytes
    input  logic        s_tuser,   // first_word
    input  logic        s_tlast,   // last_word
    // result records out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // channel_address, time_value, station_group,
                                   // group_index, fault_code, zero pad
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);

    dbhu_pkg::cfg_t  cfg_reg;
    dbhu_pkg::pair_t push_data;
    dbhu_pkg::rec_t  out_rec;
    logic            push_valid;
    logic            word_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_value  <= dbhu_pkg::MAGIC_VALUE_RESET;
            cfg_reg.source_limit <= dbhu_pkg::SOURCE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbhu_pkg::CFG_MAGIC_VALUE:  cfg_reg.magic_value  <= cfg_data;
                dbhu_pkg::CFG_SOURCE_LIMIT: cfg_reg.source_limit <= cfg_data[7:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign word_valid = s_tvalid && s_tready;

    // word decode and parse state
    dbhu_parser #(
        .GROUPS_PER_BANK (GROUPS_PER_BANK)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .word_valid    (word_valid),
        .bank_word     (s_tdata[15:0]),
        .first_word    (s_tuser),
        .last_word     (s_tlast),
        .source_number (s_tdata[23:16]),
        .header_magic  (s_tdata[39:24]),
        .bank_bytes    (s_tdata[55:40]),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    // result queue
    dbhu_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    // output word packing
    assign m_tdata = {1'b0, out_rec.fault_code, out_rec.group_index,
                      out_rec.station_group, out_rec.time_value,
                      out_rec.channel_address};
    assign m_tuser = out_rec.result_kind;
    assign m_tlast = out_rec.last_of_run;

    // error records carry a fault and no hit payload
    a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == dbhu_pkg::KIND_ERROR |->
            m_tdata[15:0] == 16'd0 && m_tdata[22:20] != dbhu_pkg::FAULT_NONE)
        else $error("error record with hit payload or no fault code");

    // hit records carry no fault
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == dbhu_pkg::KIND_HIT |->
            m_tdata[22:20] == dbhu_pkg::FAULT_NONE)
        else $error("hit record with fault code");

    // input back-pressure only while records wait to be sent
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result queue");

endmodule

FILE: tb/sv/detector_bank_hit_unpacker_test.sv
// ----------------------------------------------------------------------------
// detector_bank_hit_unpacker_test
// Self-checking bench for the bank hit unpacker. Words are sent in bursts
// with gaps, and the output stalls on its own pattern. Every accepted word
// is decoded by a bank decoder inside the bench, which yields the records it
// expects in order. A short table of hand-made banks runs first: header
// faults, empty and full groups, overrun, early end and a bank restarted
// mid-way. Random banks follow under several register settings.
// ----------------------------------------------------------------------------
module detector_bank_hit_unpacker_test;

    timeunit 1ns;
    timeprecision 1ps;

    // one bank word as offered on the input, plus an optional typed fault
    typedef struct packed {
        logic [15:0] word;
        logic        first;
        logic        last;
        logic [7:0]  src;
        logic [15:0] magic;
        logic [15:0] bytes;
        logic [2:0]  typed_fault;
        logic [1:0]  typed_station;
    } bank_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // bank decoder state and its copy of the registers
    logic [15:0]      cur_magic;
    logic [7:0]       cur_source_limit;
    dbhu_pkg::phase_t bank_phase;
    logic [16:0]      words_left;
    logic [2:0]       bank_group;
    logic [1:0]       bank_station;
    logic             bank_faulted;

    dbhu_pkg::rec_t expected_records[$];
    bank_word_t     bank_words[$];
    bank_word_t     cur_word;
    logic           hold_off_req = 1'b0;
    int             fail_count = 0;
    int             records_seen = 0;

    // hand-made banks; a typed fault replaces the decoder's record
    bank_word_t directed_rows [25] = '{
        '{16'h1234, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b1, 1'b0, 8'd0, 16'h0000, 16'd12, dbhu_pkg::FAULT_BAD_MAGIC, 2'd0},
        '{16'h0000, 1'b1, 1'b0, 8'd14, dbhu_pkg::MAGIC_VALUE_RESET, 16'd12,
          dbhu_pkg::FAULT_BAD_SOURCE, 2'd3},
        '{16'h0000, 1'b1, 1'b0, 8'd5, dbhu_pkg::MAGIC_VALUE_RESET, 16'd11,
          dbhu_pkg::FAULT_TOO_SHORT, 2'd1},
        '{16'hFFFF, 1'b1, 1'b0, 8'd7, dbhu_pkg::MAGIC_VALUE_RESET, 16'hFFFF,
          dbhu_pkg::FAULT_PREAMBLE, 2'd2},
        '{16'hFFFF, 1'b0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b1, 1'b0, 8'd13, dbhu_pkg::MAGIC_VALUE_RESET, 16'hFFFF,
          dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0001, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'hFFFF, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0002, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'hA5C3, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0001, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h5A3C, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0001, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0002, 1'b0, 1'b1, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b1, 1'b0, 8'd0, dbhu_pkg::MAGIC_VALUE_RESET, 16'd12,
          dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h7777, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0001, 1'b0, 1'b0, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h8001, 1'b0, 1'b1, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0000, 1'b1, 1'b0, 8'd4, dbhu_pkg::MAGIC_VALUE_RESET, 16'd12,
          dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h0002, 1'b1, 1'b0, 8'd6, dbhu_pkg::MAGIC_VALUE_RESET, 16'd12,
          dbhu_pkg::FAULT_NONE, 2'd0},
        '{16'h3333, 1'b0, 1'b1, 8'd0, 16'h0000, 16'd0, dbhu_pkg::FAULT_NONE, 2'd0}
    };

    detector_bank_hit_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("mismatch at record %0d: %s got %0d expected %0d",
                     records_seen, what, got, want);
        fail_count++;
    endtask

    function automatic dbhu_pkg::rec_t make_record(input logic kind, input logic [15:0] w,
                                                   input logic [2:0] code);
        dbhu_pkg::rec_t r;
        r.result_kind     = kind;
        r.channel_address = w[11:0];
        r.time_value      = w[15:12];
        r.station_group   = bank_station;
        r.group_index     = bank_group[1:0];
        r.fault_code      = code;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    function automatic void advance_group();
        if (int'(bank_group) + 1 >= dbhu_pkg::GROUPS_PER_BANK_DEFAULT)
            bank_phase = dbhu_pkg::PH_DONE;
        else
        begin
            bank_group++;
            bank_phase = dbhu_pkg::PH_COUNT;
        end
    endfunction

    // decode one accepted word and queue the records it should cause
    function automatic void decode_bank_word(input bank_word_t it);
        dbhu_pkg::rec_t recs[$];
        dbhu_pkg::rec_t r;
        int unsigned    pre;
        logic [2:0]     code;
        if (it.first)
        begin
            pre = 2 * ((int'(it.word) + 3) / 2);
            bank_station = (it.src < dbhu_pkg::STATION_BOUND_0) ? 2'd0 :
                           (it.src < dbhu_pkg::STATION_BOUND_1) ? 2'd1 :
                           (it.src < dbhu_pkg::STATION_BOUND_2) ? 2'd2 : 2'd3;
            bank_group   = '0;
            bank_faulted = 1'b0;
            code = dbhu_pkg::FAULT_NONE;
            if (it.magic != cur_magic)
                code = dbhu_pkg::FAULT_BAD_MAGIC;
            else if (it.src >= cur_source_limit)
                code = dbhu_pkg::FAULT_BAD_SOURCE;
            else if (it.bytes < dbhu_pkg::MIN_BANK_BYTES)
                code = dbhu_pkg::FAULT_TOO_SHORT;
            else if (int'(it.bytes) / 2 < pre)
                code = dbhu_pkg::FAULT_PREAMBLE;
            if (code != dbhu_pkg::FAULT_NONE)
            begin
                recs.push_back(make_record(dbhu_pkg::KIND_ERROR, 16'd0, code));
                bank_faulted = 1'b1;
                words_left   = '0;
                bank_phase   = dbhu_pkg::PH_PREAMBLE;
            end
            else
            begin
                words_left = 17'(pre - 1);
                bank_phase = (words_left == 0) ? dbhu_pkg::PH_COUNT : dbhu_pkg::PH_PREAMBLE;
            end
        end
        else if (bank_phase == dbhu_pkg::PH_IDLE)
            return;
        else if (!bank_faulted)
        begin
            case (bank_phase)
                dbhu_pkg::PH_PREAMBLE:
                begin
                    words_left--;
                    if (words_left == 0)
                        bank_phase = dbhu_pkg::PH_COUNT;
                end
                dbhu_pkg::PH_COUNT:
                begin
                    words_left = {1'b0, it.word};
                    if (it.word == 0)
                        advance_group();
                    else
                        bank_phase = dbhu_pkg::PH_HITS;
                end
                dbhu_pkg::PH_HITS:
                begin
                    recs.push_back(make_record(dbhu_pkg::KIND_HIT, it.word,
                                               dbhu_pkg::FAULT_NONE));
                    words_left--;
                    if (words_left == 0)
                        advance_group();
                end
                default:
                begin
                    recs.push_back(make_record(dbhu_pkg::KIND_ERROR, 16'd0,
                                               dbhu_pkg::FAULT_LENGTH));
                    bank_faulted = 1'b1;
                end
            endcase
        end

        // end of bank: short banks are flagged, then back to idle
        if (it.last)
        begin
            if (!bank_faulted && bank_phase != dbhu_pkg::PH_DONE)
                recs.push_back(make_record(dbhu_pkg::KIND_ERROR, 16'd0,
                                           dbhu_pkg::FAULT_LENGTH));
            bank_phase   = dbhu_pkg::PH_IDLE;
            words_left   = '0;
            bank_group   = '0;
            bank_faulted = 1'b0;
        end

        if (recs.size() != 0)
            recs[recs.size() - 1].last_of_run = 1'b1;
        foreach (recs[i])
        begin
            r = recs[i];
            expected_records.push_back(r);
        end
    endfunction

    // input acceptance and output checking
    always @(posedge clk)
    begin
        dbhu_pkg::rec_t seen;
        dbhu_pkg::rec_t want;
        int             before_n;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                before_n = expected_records.size();
                decode_bank_word(cur_word);
                if (cur_word.typed_fault != dbhu_pkg::FAULT_NONE)
                begin
                    while (expected_records.size() > before_n)
                        void'(expected_records.pop_back());
                    want = '{result_kind: dbhu_pkg::KIND_ERROR, channel_address: 12'd0,
                             time_value: 4'd0, station_group: cur_word.typed_station,
                             group_index: 2'd0, fault_code: cur_word.typed_fault,
                             last_of_run: 1'b1};
                    expected_records.push_back(want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                records_seen++;
                seen.result_kind     = m_tuser;
                seen.channel_address = m_tdata[11:0];
                seen.time_value      = m_tdata[15:12];
                seen.station_group   = m_tdata[17:16];
                seen.group_index     = m_tdata[19:18];
                seen.fault_code      = m_tdata[22:20];
                seen.last_of_run     = m_tlast;
                if (expected_records.size() == 0)
                    report_mismatch("unexpected record", int'(seen), 0);
                else
                begin
                    want = expected_records.pop_front();
                    if (seen.result_kind !== want.result_kind)
                        report_mismatch("result_kind", seen.result_kind, want.result_kind);
                    if (seen.channel_address !== want.channel_address)
                        report_mismatch("channel_address", seen.channel_address,
                                        want.channel_address);
                    if (seen.time_value !== want.time_value)
                        report_mismatch("time_value", seen.time_value, want.time_value);
                    if (seen.station_group !== want.station_group)
                        report_mismatch("station_group", seen.station_group,
                                        want.station_group);
                    if (seen.group_index !== want.group_index)
                        report_mismatch("group_index", seen.group_index, want.group_index);
                    if (seen.fault_code !== want.fault_code)
                        report_mismatch("fault_code", seen.fault_code, want.fault_code);
                    if (seen.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", seen.last_of_run, want.last_of_run);
                end
            end
        end
    end

    // output side: changing stall patterns, and one long hold-off on request
    initial
    begin
        int stall_mode;
        int mode_left;
        int hold_cnt;
        int cyc;
        m_tready   = 1'b0;
        stall_mode = 0;
        mode_left  = 0;
        cyc        = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < 120; hold_cnt++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(8, 64);
            end
            mode_left--;
            cyc++;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (cyc % 3 == 0);
            endcase
        end
    end

    task automatic write_register(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == dbhu_pkg::CFG_MAGIC_VALUE)
            cur_magic = value;
        else
            cur_source_limit = value[7:0];
    endtask

    task automatic send_word(input bank_word_t it);
        @(negedge clk);
        cur_word = it;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.bytes, it.magic, it.src, it.word};
        s_tuser  <= it.first;
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // send everything queued, in bursts with random gaps
    task automatic run_bank_words();
        bank_word_t it;
        int         burst_left;
        int         gap;
        burst_left = $urandom_range(1, 20);
        while (bank_words.size() != 0)
        begin
            it = bank_words.pop_front();
            send_word(it);
            burst_left--;
            if (burst_left == 0 && bank_words.size() != 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // wait for outstanding records, then let the bench settle
    task automatic drain_records(input int settle);
        int waited;
        waited = 0;
        while (expected_records.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    function automatic bank_word_t random_word();
        bank_word_t it;
        it.word          = 16'($urandom);
        it.first         = 1'b0;
        it.last          = 1'b0;
        it.src           = 8'($urandom);
        it.magic         = 16'($urandom);
        it.bytes         = 16'($urandom);
        it.typed_fault   = dbhu_pkg::FAULT_NONE;
        it.typed_station = 2'd0;
        return it;
    endfunction

    // queue one random bank: mostly well formed, some faulty, some noise
    task automatic add_random_bank();
        bank_word_t  it;
        bank_word_t  body[$];
        int unsigned dice;
        int unsigned w;
        int unsigned pre;
        int unsigned total;
        int unsigned counts[4];
        int unsigned cut;
        dice = $urandom_range(0, 99);
        it   = random_word();
        if (dice < 70)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
            pre = 2 * ((w + 3) / 2);
            total = pre;
            for (int g = 0; g < 4; g++)
            begin
                counts[g] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8)
                                                        : $urandom_range(0, 3);
                total += 1 + counts[g];
            end
            it.first = 1'b1;
            it.word  = 16'(w);
            it.src   = 8'($urandom_range(0, int'(cur_source_limit) - 1));
            it.magic = cur_magic;
            it.bytes = 16'(2 * total + 2 * $urandom_range(0, 4));
            body.push_back(it);
            repeat (pre - 1) body.push_back(random_word());
            for (int g = 0; g < 4; g++)
            begin
                it = random_word();
                it.word = 16'(counts[g]);
                body.push_back(it);
                repeat (counts[g]) body.push_back(random_word());
            end
            dice = $urandom_range(0, 99);
            if (dice < 15)
            begin
                // bank cut short
                cut = $urandom_range(1, body.size() - 1);
                while (body.size() > cut)
                    void'(body.pop_back());
            end
            else if (dice < 25)
            begin
                // words past the last group
                repeat ($urandom_range(1, 3)) body.push_back(random_word());
            end
        end
        else if (dice < 80)
        begin
            // header fault of one kind
            it.first = 1'b1;
            it.magic = cur_magic;
            it.src   = 8'($urandom_range(0, int'(cur_source_limit) - 1));
            it.bytes = 16'($urandom_range(12, 65535));
            it.word  = 16'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0: it.magic = cur_magic ^ (16'd1 << $urandom_range(0, 15));
                1: it.src   = 8'($urandom_range(int'(cur_source_limit), 255));
                2: it.bytes = 16'($urandom_range(0, 11));
                default: it.word = 16'(65535 - $urandom_range(0, 100));
            endcase
            body.push_back(it);
            repeat ($urandom_range(0, 4)) body.push_back(random_word());
        end
        else if (dice < 90)
        begin
            // stray words outside any bank
            repeat ($urandom_range(1, 3)) body.push_back(random_word());
        end
        else
        begin
            // anything goes
            repeat ($urandom_range(1, 8))
            begin
                it = random_word();
                it.first = ($urandom_range(0, 3) == 0);
                it.last  = ($urandom_range(0, 4) == 0);
                body.push_back(it);
            end
        end
        body[body.size() - 1].last = 1'b1;
        foreach (body[i])
            bank_words.push_back(body[i]);
    endtask

    // main sequence
    initial
    begin
        dbhu_pkg::rec_t want;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = dbhu_pkg::CFG_MAGIC_VALUE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cur_word  = '0;
        cur_magic        = dbhu_pkg::MAGIC_VALUE_RESET;
        cur_source_limit = dbhu_pkg::SOURCE_LIMIT_RESET;
        bank_phase   = dbhu_pkg::PH_IDLE;
        words_left   = '0;
        bank_group   = '0;
        bank_station = '0;
        bank_faulted = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hand-made banks under reset register values
        foreach (directed_rows[i])
            bank_words.push_back(directed_rows[i]);
        run_bank_words();
        drain_records(6);

        // random banks under several register settings
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_register(dbhu_pkg::CFG_MAGIC_VALUE, 16'($urandom));
                    write_register(dbhu_pkg::CFG_SOURCE_LIMIT, 16'd255);
                    hold_off_req = 1'b1;
                end
                1:
                begin
                    write_register(dbhu_pkg::CFG_MAGIC_VALUE, 16'h0000);
                    write_register(dbhu_pkg::CFG_SOURCE_LIMIT, 16'd1);
                end
                2:
                begin
                    write_register(dbhu_pkg::CFG_MAGIC_VALUE, 16'hFFFF);
                    write_register(dbhu_pkg::CFG_SOURCE_LIMIT,
                                   16'($urandom_range(2, 254)));
                end
                default:
                begin
                    write_register(dbhu_pkg::CFG_MAGIC_VALUE, dbhu_pkg::MAGIC_VALUE_RESET);
                    write_register(dbhu_pkg::CFG_SOURCE_LIMIT,
                                   16'(dbhu_pkg::SOURCE_LIMIT_RESET));
                end
            endcase
            while (bank_words.size() < 115)
                add_random_bank();
            run_bank_words();
            drain_records(6);
        end

        drain_records(16);
        while (expected_records.size() != 0)
        begin
            want = expected_records.pop_front();
            report_mismatch("record never arrived", 0, int'(want));
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dbhu_pkg.sv
rtl/core/dbhu_parser.sv
rtl/core/dbhu_out_queue.sv
rtl/core/detector_bank_hit_unpacker.sv
tb/sv/detector_bank_hit_unpacker_test.sv
